### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/wfba_pkg.sv
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared types and constants of the worst-fit block allocator.
// ----------------------------------------------------------------------------
package wfba_pkg;

    localparam int NUM_BLOCKS_DEF = 32;
    localparam int SIZE_WIDTH_DEF = 16;

    localparam int SIZE_FIELD_W  = 16;
    localparam int INDEX_FIELD_W = 5;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_ALLOC = 1'b1
    } opcode_t;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

### rtl/core/wfba_req_if.sv
// ----------------------------------------------------------------------------
// wfba_req_if
// Request channel: load a block size or ask for an allocation.
// ----------------------------------------------------------------------------
interface wfba_req_if;
    import wfba_pkg::*;

    logic                    valid;
    logic                    ready;
    opcode_t                 opcode;
    logic [SIZE_FIELD_W-1:0] size_value;

    modport source
    (
        output valid,
        output opcode,
        output size_value,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  opcode,
        input  size_value,
        output ready
    );
endinterface

### rtl/core/wfba_rsp_if.sv
// ----------------------------------------------------------------------------
// wfba_rsp_if
// Response channel: outcome of one allocation request.
// ----------------------------------------------------------------------------
interface wfba_rsp_if;
    import wfba_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     granted;
    logic [INDEX_FIELD_W-1:0] block_index;
    logic [SIZE_FIELD_W-1:0]  chosen_block_size;
    logic [SIZE_FIELD_W-1:0]  leftover;

    modport source
    (
        output valid,
        output granted,
        output block_index,
        output chosen_block_size,
        output leftover,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  granted,
        input  block_index,
        input  chosen_block_size,
        input  leftover,
        output ready
    );
endinterface

### rtl/core/wfba_ram.sv
// ----------------------------------------------------------------------------
// wfba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wfba_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

### rtl/core/worst_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// worst_fit_block_allocator_top
// Worst-fit allocator over a table of loaded block sizes.
// ----------------------------------------------------------------------------
// A load request appends a block size; loads past NUM_BLOCKS are dropped. An
// allocate request walks the loaded blocks one per cycle through the single
// read port of the block-size RAM and one shared subtract-and-compare unit,
// so it occupies the block through the scan and done states, until its result
// is committed to the output register, before the next request is taken.
// The response sits in an output register, so a new request is accepted while
// the previous response waits. Reset clears the block count and all allocated
// flags; no clearing pass is needed.
`include "assert_macros.svh"

module worst_fit_block_allocator_top #(
    parameter int NUM_BLOCKS = wfba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = wfba_pkg::SIZE_WIDTH_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    wfba_req_if.sink    req,
    wfba_rsp_if.source  rsp
);
    import wfba_pkg::*;

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           scan_idx_reg, scan_idx_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic                    found_reg, found_next;
    logic [NUM_BLOCKS-1:0]   alloc_reg, alloc_next;
    logic                    out_valid_reg, out_valid_next;

    logic [AW-1:0]           cmp_idx_reg;
    logic [SIZE_WIDTH-1:0]   req_size_reg;
    logic [AW-1:0]           best_idx_reg;
    logic [SIZE_WIDTH-1:0]   best_left_reg;
    logic [SIZE_WIDTH-1:0]   best_size_reg;
    logic                    out_granted_reg;
    logic [AW-1:0]           out_idx_reg;
    logic [SIZE_WIDTH-1:0]   out_size_reg;
    logic [SIZE_WIDTH-1:0]   out_left_reg;

    logic                    req_fire;
    logic                    load_wr;
    logic                    issue;
    logic                    fits;
    logic                    take;
    logic                    commit;
    logic [SIZE_WIDTH-1:0]   rd_data;
    logic [SIZE_WIDTH-1:0]   cand_left;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign load_wr   = req_fire && (req.opcode == OP_LOAD) && (count_reg < CW'(NUM_BLOCKS));
    assign issue     = (state_reg == ST_SCAN) && (scan_idx_reg < count_reg);
    assign cand_left = rd_data - req_size_reg;
    assign fits      = cmp_valid_reg && !alloc_reg[cmp_idx_reg] && (rd_data >= req_size_reg);
    assign take      = fits && (!found_reg || (cand_left > best_left_reg));
    assign commit    = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    wfba_ram #(
        .WIDTH (SIZE_WIDTH),
        .DEPTH (NUM_BLOCKS)
    ) u_size_ram (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (SIZE_WIDTH'(req.size_value)),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        found_next     = found_reg;
        alloc_next     = alloc_reg;
        out_valid_next = out_valid_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (load_wr)
                begin
                    count_next = count_reg + CW'(1);
                end
                if (req_fire && (req.opcode == OP_ALLOC))
                begin
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    found_next = 1'b1;
                end
                if (issue)
                begin
                    scan_idx_next  = scan_idx_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    if (found_reg)
                    begin
                        alloc_next[best_idx_reg] = 1'b1;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            alloc_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            alloc_reg     <= alloc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && (req.opcode == OP_ALLOC))
        begin
            req_size_reg <= SIZE_WIDTH'(req.size_value);
        end
        if (issue)
        begin
            cmp_idx_reg <= scan_idx_reg[AW-1:0];
        end
        if (take)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_left_reg <= cand_left;
            best_size_reg <= rd_data;
        end
        if (commit)
        begin
            out_granted_reg <= found_reg;
            out_idx_reg     <= found_reg ? best_idx_reg  : '0;
            out_size_reg    <= found_reg ? best_size_reg : '0;
            out_left_reg    <= found_reg ? best_left_reg : '0;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.granted           = out_granted_reg;
    assign rsp.block_index       = INDEX_FIELD_W'(out_idx_reg);
    assign rsp.chosen_block_size = SIZE_FIELD_W'(out_size_reg);
    assign rsp.leftover          = SIZE_FIELD_W'(out_left_reg);

    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(NUM_BLOCKS),
        "block count above capacity")
    `ASSERT_IMPLIES(a_scan_bound, clk, rst_n, state_reg == ST_SCAN, scan_idx_reg <= count_reg,
        "scan index past loaded blocks")
    `ASSERT_IMPLIES(a_grant_marked, clk, rst_n, out_valid_reg && out_granted_reg,
        alloc_reg[out_idx_reg] && (out_size_reg >= out_left_reg),
        "granted block not marked allocated or leftover exceeds size")
    `ASSERT_NEXT(a_commit_marks, clk, rst_n, commit && found_reg,
        out_valid_reg && alloc_reg[$past(best_idx_reg)],
        "commit did not mark chosen block")
endmodule
